### rtl/core/apbd_pkg.sv
// apbd_pkg: widths, codes, payload types and control structs shared by the
// adaptive pulse beat detector. No dependencies.
package apbd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int BASE_W      = SAMPLE_BITS + FRAC_BITS;
  localparam int ALPHA_W     = 16;
  localparam int TF_W        = 12;
  localparam int REFR_W      = 16;
  localparam int RATE_W      = 10;
  localparam int TIME_W      = 32;
  localparam int THR_ADD_W   = TF_W + BASE_W - FRAC_BITS;
  localparam int THR_W       = THR_ADD_W + 1;
  localparam int THR_OUT_W   = THR_W - FRAC_BITS;
  localparam int MUL_A_W     = BASE_W;
  localparam int MUL_B_W     = ALPHA_W + 1;
  localparam int ACC_W       = MUL_A_W + MUL_B_W;
  localparam int Q_W         = 16;
  localparam int CNT_W       = $clog2(Q_W);
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  localparam logic [Q_W-1:0] RATE_NUM = Q_W'(60000);

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ALPHA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEV_ALPHA   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FRAC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE    = 3'd5;

  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_RECAL   = 2'd1;
  localparam logic [1:0] FUNC_CONSUME = 2'd2;

  localparam logic [ALPHA_W-1:0] BASE_ALPHA_RST = ALPHA_W'(655);
  localparam logic [ALPHA_W-1:0] DEV_ALPHA_RST  = ALPHA_W'(3277);
  localparam logic [TF_W-1:0]    TF_RST         = TF_W'(128);
  localparam logic [REFR_W-1:0]  REFR_RST       = REFR_W'(300);
  localparam logic [RATE_W-1:0]  MIN_RATE_RST   = RATE_W'(40);
  localparam logic [RATE_W-1:0]  MAX_RATE_RST   = RATE_W'(200);

  localparam logic [BASE_W-1:0]      DEV_FLOOR     = BASE_W'(10 << FRAC_BITS);
  localparam logic [SAMPLE_BITS-1:0] CHANGE_STEP   = SAMPLE_BITS'(2);
  localparam logic [MUL_B_W-1:0]     SMOOTH_WEIGHT = MUL_B_W'(7);
  localparam int                     SMOOTH_SHIFT  = 3;
  localparam logic [MUL_B_W-1:0]     ALPHA_ONE     = MUL_B_W'(1) << ALPHA_W;
  localparam logic [ACC_W-1:0]       EWMA_ROUND    = ACC_W'(1) << (ALPHA_W - 1);
  localparam logic [ACC_W-1:0]       THR_ROUND     = ACC_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [1:0]             func;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_W-1:0]      now_ms;
  } req_t;

  typedef struct packed {
    logic                   beat_flag;
    logic [RATE_W-1:0]      rate;
    logic [RATE_W-1:0]      rate_smooth;
    logic [THR_OUT_W-1:0]   threshold;
    logic [SAMPLE_BITS-1:0] sample_min;
    logic [SAMPLE_BITS-1:0] sample_max;
    logic [TIME_W-1:0]      last_beat_time;
    logic [TIME_W-1:0]      last_change_time;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic add;
  } mac_ctl_t;

endpackage

### rtl/core/adaptive_pulse_beat_detector.sv
// adaptive_pulse_beat_detector: top level with sequencer, state and config registers.
// Depends on apbd_pkg, apbd_mac, apbd_div.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_data  (req_t)
//  rsp      out        rsp_valid/rsp_stall   rsp_data  (rsp_t)
//  cfg      in         cfg_write             cfg_index, cfg_data
//
// Sample request: averages, threshold, crossing test, then divider and smoothing on an
// accepted crossing. Recalibrate re-seeds baseline and threshold; consume goes to the response.
// The shared multiply-accumulate unit runs the averages, the threshold and the
// smoothing in turn. Reset is synchronous; config returns to defaults.
// req_stall is high while a request is in work; a stalled response holds, and the
// next request may enter while it waits.
module adaptive_pulse_beat_detector
  import apbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_B0    = 5'd1;
  localparam logic [4:0] ST_B1    = 5'd2;
  localparam logic [4:0] ST_B2    = 5'd3;
  localparam logic [4:0] ST_D0    = 5'd4;
  localparam logic [4:0] ST_D1    = 5'd5;
  localparam logic [4:0] ST_D2    = 5'd6;
  localparam logic [4:0] ST_T0    = 5'd7;
  localparam logic [4:0] ST_RECAL = 5'd8;
  localparam logic [4:0] ST_T1    = 5'd9;
  localparam logic [4:0] ST_T2    = 5'd10;
  localparam logic [4:0] ST_T3    = 5'd11;
  localparam logic [4:0] ST_CROSS = 5'd12;
  localparam logic [4:0] ST_DIV   = 5'd13;
  localparam logic [4:0] ST_RATE  = 5'd14;
  localparam logic [4:0] ST_SM1   = 5'd15;
  localparam logic [4:0] ST_SM2   = 5'd16;
  localparam logic [4:0] ST_DONE  = 5'd17;

  logic [4:0] state;
  req_t       item;

  logic [ALPHA_W-1:0] base_weight;
  logic [ALPHA_W-1:0] dev_alpha;
  logic [TF_W-1:0]    thr_gain;
  logic [REFR_W-1:0]  holdoff_ms;
  logic [RATE_W-1:0]  min_rate;
  logic [RATE_W-1:0]  max_rate;

  logic [BASE_W-1:0]      baseline;
  logic [BASE_W-1:0]      deviation;
  logic [BASE_W-1:0]      dev_abs;
  logic [THR_W-1:0]       thresh_value;
  logic [SAMPLE_BITS-1:0] min_seen;
  logic [SAMPLE_BITS-1:0] max_seen;
  logic [SAMPLE_BITS-1:0] prev_sample;
  logic                   prev_valid;
  logic [TIME_W-1:0]      beat_time;
  logic [TIME_W-1:0]      change_time;
  logic [RATE_W-1:0]      inst_rate;
  logic [RATE_W-1:0]      smooth_rate;
  logic                   flag_pending;
  logic                   was_above;
  logic                   dt_zero;

  mac_ctl_t           mac_ctl;
  logic [MUL_A_W-1:0] mac_a;
  logic [MUL_B_W-1:0] mac_b;
  logic [ACC_W-1:0]   mac_init;
  logic [ACC_W-1:0]   acc;

  logic              div_start;
  logic              div_done;
  logic [Q_W-1:0]    div_q;

  logic [BASE_W-1:0]      s;
  logic [BASE_W-1:0]      ewma_res;
  logic [THR_ADD_W-1:0]   thr_add;
  logic [SAMPLE_BITS-1:0] step;
  logic [TIME_W-1:0]      dt;
  logic                   above;
  logic                   crossing;
  logic [Q_W-1:0]         inst;
  logic                   in_range;
  logic [BASE_W-1:0]      half_dev;

  assign s        = {item.sample, {FRAC_BITS{1'b0}}};
  assign ewma_res = acc[ALPHA_W +: BASE_W];
  assign thr_add  = acc[FRAC_BITS +: THR_ADD_W];
  assign step     = (item.sample > prev_sample) ? item.sample - prev_sample
                                                : prev_sample - item.sample;
  assign dt       = item.now_ms - beat_time;
  assign above    = {{(THR_OUT_W-SAMPLE_BITS){1'b0}}, item.sample} >
                    thresh_value[THR_W-1:FRAC_BITS];
  assign crossing = !was_above && above &&
                    (dt >= {{(TIME_W-REFR_W){1'b0}}, holdoff_ms});
  assign div_start = (state == ST_CROSS) && crossing && (dt != '0);
  assign inst     = dt_zero ? '0 : div_q;
  assign in_range = (inst >= {{(Q_W-RATE_W){1'b0}}, min_rate}) &&
                    (inst <= {{(Q_W-RATE_W){1'b0}}, max_rate});
  assign half_dev = (max_seen > min_seen)
                  ? BASE_W'({max_seen - min_seen, {(FRAC_BITS-1){1'b0}}}) : '0;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    mac_ctl  = '0;
    mac_a    = baseline;
    mac_b    = ALPHA_ONE - {1'b0, base_weight};
    mac_init = EWMA_ROUND;
    unique case (state)
      ST_B0: begin
        mac_ctl.clr = 1'b1;
      end
      ST_B1: begin
        mac_ctl.add = 1'b1;
        mac_a       = s;
        mac_b       = {1'b0, base_weight};
      end
      ST_B2, ST_D2, ST_T2, ST_SM1: begin
        mac_ctl.add = 1'b1;
      end
      ST_D0: begin
        mac_ctl.clr = 1'b1;
        mac_a       = deviation;
        mac_b       = ALPHA_ONE - {1'b0, dev_alpha};
      end
      ST_D1: begin
        mac_ctl.add = 1'b1;
        mac_a       = dev_abs;
        mac_b       = {1'b0, dev_alpha};
      end
      ST_T0, ST_RECAL: begin
        mac_ctl.clr = 1'b1;
        mac_init    = THR_ROUND;
      end
      ST_T1: begin
        mac_a = deviation;
        mac_b = MUL_B_W'(thr_gain);
      end
      ST_RATE: begin
        mac_ctl.clr = 1'b1;
        mac_init    = ACC_W'(inst);
        mac_a       = MUL_A_W'(smooth_rate);
        mac_b       = SMOOTH_WEIGHT;
      end
      default: begin
      end
    endcase
  end

  apbd_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (acc)
  );

  apbd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (dt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_weight <= BASE_ALPHA_RST;
      dev_alpha   <= DEV_ALPHA_RST;
      thr_gain    <= TF_RST;
      holdoff_ms  <= REFR_RST;
      min_rate    <= MIN_RATE_RST;
      max_rate    <= MAX_RATE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE_ALPHA:  base_weight <= cfg_data[ALPHA_W-1:0];
        REG_DEV_ALPHA:   dev_alpha   <= cfg_data[ALPHA_W-1:0];
        REG_THRESH_FRAC: thr_gain    <= cfg_data[TF_W-1:0];
        REG_REFRACTORY:  holdoff_ms  <= cfg_data[REFR_W-1:0];
        REG_MIN_RATE:    min_rate    <= cfg_data[RATE_W-1:0];
        REG_MAX_RATE:    max_rate    <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rsp_valid    <= 1'b0;
      baseline     <= '0;
      deviation    <= '0;
      thresh_value <= '0;
      min_seen     <= '1;
      max_seen     <= '0;
      prev_sample  <= '0;
      prev_valid   <= 1'b0;
      beat_time    <= '0;
      change_time  <= '0;
      inst_rate    <= '0;
      smooth_rate  <= '0;
      flag_pending <= 1'b0;
      was_above    <= 1'b0;
      dt_zero      <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != ST_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item <= req_data;
            if (req_data.func == FUNC_SAMPLE) begin
              state <= ST_B0;
            end else if (req_data.func == FUNC_RECAL) begin
              state <= ST_RECAL;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_B0: begin
          if (item.sample < min_seen) min_seen <= item.sample;
          if (item.sample > max_seen) max_seen <= item.sample;
          if (prev_valid && step > CHANGE_STEP) change_time <= item.now_ms;
          prev_sample <= item.sample;
          prev_valid  <= 1'b1;
          state       <= ST_B1;
        end
        ST_B1: state <= ST_B2;
        ST_B2: state <= ST_D0;
        ST_D0: begin
          baseline <= ewma_res;
          dev_abs  <= (s > ewma_res) ? s - ewma_res : ewma_res - s;
          state    <= ST_D1;
        end
        ST_D1: state <= ST_D2;
        ST_D2: state <= ST_T0;
        ST_T0: begin
          deviation <= ewma_res;
          state     <= ST_T1;
        end
        ST_RECAL: begin
          baseline    <= {{1'b0, min_seen} + {1'b0, max_seen}, {(FRAC_BITS-1){1'b0}}};
          deviation   <= (half_dev < DEV_FLOOR) ? DEV_FLOOR : half_dev;
          beat_time   <= item.now_ms;
          change_time <= item.now_ms;
          min_seen    <= '1;
          max_seen    <= '0;
          state       <= ST_T1;
        end
        ST_T1: state <= ST_T2;
        ST_T2: state <= ST_T3;
        ST_T3: begin
          thresh_value <= {{(THR_W-BASE_W){1'b0}}, baseline} + {1'b0, thr_add};
          state        <= (item.func == FUNC_SAMPLE) ? ST_CROSS : ST_DONE;
        end
        ST_CROSS: begin
          was_above <= above;
          if (crossing) begin
            beat_time <= item.now_ms;
            dt_zero   <= (dt == '0);
            state     <= (dt == '0) ? ST_RATE : ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_RATE;
        end
        ST_RATE: begin
          if (in_range) begin
            inst_rate    <= inst[RATE_W-1:0];
            flag_pending <= 1'b1;
            if (smooth_rate == '0) begin
              smooth_rate <= inst[RATE_W-1:0];
              state       <= ST_DONE;
            end else begin
              state <= ST_SM1;
            end
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SM1: state <= ST_SM2;
        ST_SM2: begin
          smooth_rate <= acc[SMOOTH_SHIFT +: RATE_W];
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid                 <= 1'b1;
            rsp_data.beat_flag        <= flag_pending;
            rsp_data.rate             <= inst_rate;
            rsp_data.rate_smooth      <= smooth_rate;
            rsp_data.threshold        <= thresh_value[THR_W-1:FRAC_BITS];
            rsp_data.sample_min       <= min_seen;
            rsp_data.sample_max       <= max_seen;
            rsp_data.last_beat_time   <= beat_time;
            rsp_data.last_change_time <= change_time;
            if (item.func == FUNC_CONSUME) flag_pending <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/apbd_mac.sv
// apbd_mac: shared multiply-accumulate unit, registered product then accumulator.
// Depends on apbd_pkg.
module apbd_mac
  import apbd_pkg::*;
(
  input  logic               clk,
  input  mac_ctl_t           ctl,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  input  logic [ACC_W-1:0]   init,
  output logic [ACC_W-1:0]   acc
);

  logic [ACC_W-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= ACC_W'(a) * ACC_W'(b);
    if (ctl.clr) begin
      acc <= init;
    end else if (ctl.add) begin
      acc <= acc + prod;
    end
  end

endmodule

### rtl/core/apbd_div.sv
// apbd_div: restoring serial divider, fixed 60000 dividend, one quotient bit a cycle.
// Depends on apbd_pkg.
module apbd_div
  import apbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [Q_W-1:0]    quotient
);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [Q_W-1:0]    rem;
  logic [TIME_W-1:0] dvs;
  logic [Q_W:0]      trial;
  logic              ge;

  assign trial = {rem, RATE_NUM[cnt]};
  assign ge    = {{(TIME_W-Q_W-1){1'b0}}, trial} >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(Q_W - 1);
        rem <= '0;
        dvs <= divisor;
      end else if (run) begin
        rem      <= ge ? Q_W'(trial - dvs[Q_W:0]) : trial[Q_W-1:0];
        quotient <= {quotient[Q_W-2:0], ge};
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/apbd_checker.sv
// apbd_checker: port-level checks on the beat detector, bound to the top level.
// Depends on apbd_pkg and adaptive_pulse_beat_detector.
module apbd_checker
  import apbd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input req_t                 req_data,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input rsp_t                 rsp_data,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // one request at a time: busy right after an accepted request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while previous one in work");

  // smoothed rate can only be zero if the instant rate is zero
  a_smooth: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.rate_smooth != '0) || (rsp_data.rate == '0))
    else $error("smoothed rate zero with nonzero instant rate");

  // reset empties the output and frees the input
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("reset did not clear handshake state");

endmodule

bind adaptive_pulse_beat_detector apbd_checker u_apbd_checker (.*);

### sim/apbd_pulse_checker.sv
// apbd_pulse_checker: watches the request, response and register ports of the
// pulse beat detector, predicts every response and compares it field by field.
// Depends on apbd_pkg.
module apbd_pulse_checker
  import apbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_t                 rsp_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   errors,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [ALPHA_W-1:0] base_w, dev_w;
  logic [TF_W-1:0]    frac;
  logic [REFR_W-1:0]  refr;
  logic [RATE_W-1:0]  lo_rate, hi_rate;

  // detector state
  logic [BASE_W-1:0]      base_q, dev_q;
  logic [THR_W-1:0]       thr_q;
  logic [SAMPLE_BITS-1:0] min_s, max_s, last_s;
  logic                   have_last, above_q, flag;
  logic [TIME_W-1:0]      t_beat, t_change;
  logic [RATE_W-1:0]      rate_i, rate_s;

  rsp_t expected_beats[$];

  function automatic logic [BASE_W-1:0] ema_q8(input logic [BASE_W-1:0] old, x,
                                               input logic [ALPHA_W-1:0] w);
    logic [63:0] acc;
    acc = 64'(old) * (64'd65536 - 64'(w)) + 64'(x) * 64'(w) + 64'd32768;
    return BASE_W'(acc >> 16);
  endfunction

  function automatic logic [THR_W-1:0] thr_of(input logic [BASE_W-1:0] b, d,
                                              input logic [TF_W-1:0] f);
    logic [63:0] acc;
    acc = 64'(b) + ((64'(f) * 64'(d) + 64'd128) >> 8);
    return THR_W'(acc);
  endfunction

  task automatic track_pulse(input req_t r, output rsp_t e);
    logic [BASE_W-1:0]      s_q, diff_q;
    logic [SAMPLE_BITS-1:0] step;
    logic [TIME_W-1:0]      dt;
    logic [31:0]            inst;
    logic                   hit;
    int                     spread;
    case (r.func)
      FUNC_SAMPLE: begin
        if (r.sample < min_s) min_s = r.sample;
        if (r.sample > max_s) max_s = r.sample;
        step = (r.sample > last_s) ? r.sample - last_s : last_s - r.sample;
        if (have_last && step > CHANGE_STEP) t_change = r.now_ms;
        last_s = r.sample;
        have_last = 1'b1;
        s_q = BASE_W'(r.sample) << FRAC_BITS;
        base_q = ema_q8(base_q, s_q, base_w);
        diff_q = (s_q > base_q) ? s_q - base_q : base_q - s_q;
        dev_q = ema_q8(dev_q, diff_q, dev_w);
        thr_q = thr_of(base_q, dev_q, frac);
        hit = r.sample > thr_q[THR_W-1:FRAC_BITS];
        if (!above_q && hit) begin
          dt = r.now_ms - t_beat;
          if (dt >= TIME_W'(refr)) begin
            inst = (dt != 0) ? 32'd60000 / dt : 32'd0;
            t_beat = r.now_ms;
            if (inst >= 32'(lo_rate) && inst <= 32'(hi_rate)) begin
              rate_i = RATE_W'(inst);
              rate_s = (rate_s == 0) ? RATE_W'(inst) : RATE_W'((32'(rate_s) * 7 + inst) / 8);
              flag = 1'b1;
            end
          end
        end
        above_q = hit;
      end
      FUNC_RECAL: begin
        spread = (int'(max_s) - int'(min_s)) * 128;
        if (spread < int'(DEV_FLOOR)) spread = int'(DEV_FLOOR);
        base_q = (BASE_W'(min_s) + BASE_W'(max_s)) << 7;
        dev_q = BASE_W'(spread);
        thr_q = thr_of(base_q, dev_q, frac);
        t_beat = r.now_ms;
        t_change = r.now_ms;
        min_s = '1;
        max_s = '0;
      end
      default: ;
    endcase
    e.beat_flag = flag;
    if (r.func == FUNC_CONSUME) flag = 1'b0;
    e.rate = rate_i;
    e.rate_smooth = rate_s;
    e.threshold = thr_q[THR_W-1:FRAC_BITS];
    e.sample_min = min_s;
    e.sample_max = max_s;
    e.last_beat_time = t_beat;
    e.last_change_time = t_change;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want_v, got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      base_w = BASE_ALPHA_RST;
      dev_w = DEV_ALPHA_RST;
      frac = TF_RST;
      refr = REFR_RST;
      lo_rate = MIN_RATE_RST;
      hi_rate = MAX_RATE_RST;
      base_q = '0;
      dev_q = '0;
      thr_q = '0;
      min_s = '1;
      max_s = '0;
      last_s = '0;
      have_last = 1'b0;
      above_q = 1'b0;
      flag = 1'b0;
      t_beat = '0;
      t_change = '0;
      rate_i = '0;
      rate_s = '0;
      expected_beats.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE_ALPHA:  base_w = cfg_data[ALPHA_W-1:0];
          REG_DEV_ALPHA:   dev_w = cfg_data[ALPHA_W-1:0];
          REG_THRESH_FRAC: frac = cfg_data[TF_W-1:0];
          REG_REFRACTORY:  refr = cfg_data[REFR_W-1:0];
          REG_MIN_RATE:    lo_rate = cfg_data[RATE_W-1:0];
          REG_MAX_RATE:    hi_rate = cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        track_pulse(req_data, want);
        expected_beats.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_beats.size() == 0) begin
          $error("response with no request pending");
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("beat_flag", TIME_W'(want.beat_flag), TIME_W'(rsp_data.beat_flag));
          check_field("rate", TIME_W'(want.rate), TIME_W'(rsp_data.rate));
          check_field("rate_smooth", TIME_W'(want.rate_smooth), TIME_W'(rsp_data.rate_smooth));
          check_field("threshold", TIME_W'(want.threshold), TIME_W'(rsp_data.threshold));
          check_field("sample_min", TIME_W'(want.sample_min), TIME_W'(rsp_data.sample_min));
          check_field("sample_max", TIME_W'(want.sample_max), TIME_W'(rsp_data.sample_max));
          check_field("last_beat_time", want.last_beat_time, rsp_data.last_beat_time);
          check_field("last_change_time", want.last_change_time, rsp_data.last_change_time);
        end
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

### sim/adaptive_pulse_beat_detector_tb.sv
// adaptive_pulse_beat_detector_tb: drives pulse trains, recalibrate and consume
// requests and register settings into the beat detector; apbd_pulse_checker does
// the checking. Depends on apbd_pkg, apbd_pulse_checker and the detector RTL.
module adaptive_pulse_beat_detector_tb
  import apbd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]           FUNC_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int LIMIT_CYCLES = 500000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 40;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   errors, outstanding;

  int                send_idle_pct = 21;
  int                recv_idle_pct = 87;
  int                holds_asked = 0;
  int                cycles = 0;
  logic [TIME_W-1:0] pulse_ms;

  adaptive_pulse_beat_detector uut (.*);
  apbd_pulse_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_req(input logic [1:0] fn, input logic [SAMPLE_BITS-1:0] smp,
                          input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= '{func: fn, sample: smp, now_ms: now};
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] ba, da, tf, rf, lo, hi);
    put_reg(REG_BASE_ALPHA, ba);
    put_reg(REG_DEV_ALPHA, da);
    put_reg(REG_THRESH_FRAC, tf);
    put_reg(REG_REFRACTORY, rf);
    put_reg(REG_MIN_RATE, lo);
    put_reg(REG_MAX_RATE, hi);
    put_reg(REG_SPARE_LO, CFG_W'($urandom()));
    put_reg(REG_SPARE_HI, CFG_W'($urandom()));
    cfg_write <= 1'b0;
  endtask

  // mostly beat-shaped sample trains, with consume, recalibrate and noise requests
  task automatic run_pulses(input int n_items);
    int sent_n, period, step, amp, floor_lvl, elapsed, lvl;
    sent_n = 0;
    if ($urandom_range(1)) pulse_ms = $urandom();
    else pulse_ms = 32'hFFFF_FFFF - $urandom_range(5000);
    while (sent_n < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_req(2'($urandom_range(3)), SAMPLE_BITS'($urandom()), $urandom());
          sent_n++;
        end
        1: begin
          send_req(FUNC_CONSUME, SAMPLE_BITS'($urandom()), pulse_ms);
          sent_n++;
        end
        2: begin
          if ($urandom_range(3) == 0) begin
            send_req(FUNC_RECAL, SAMPLE_BITS'($urandom()), pulse_ms);
            sent_n++;
          end
        end
        default: begin
          period = $urandom_range(1600, 250);
          step = $urandom_range(60, 8);
          amp = $urandom_range(900, 50);
          floor_lvl = $urandom_range(400, 0);
          elapsed = 0;
          while (elapsed < period && sent_n < n_items) begin
            lvl = (elapsed < 3 * step) ? floor_lvl + amp : floor_lvl + $urandom_range(6, 0);
            if (lvl > 1023) lvl = 1023;
            send_req(FUNC_SAMPLE, SAMPLE_BITS'(lvl), pulse_ms);
            sent_n++;
            elapsed += step;
            pulse_ms += TIME_W'(step);
          end
          if ($urandom_range(1)) begin
            send_req(FUNC_CONSUME, '0, pulse_ms);
            sent_n++;
          end
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty recalibrate, crossings, refractory, rejection, time wrap
    send_req(FUNC_CONSUME, '0, 32'd0);
    send_req(FUNC_UNUSED, 10'd1023, 32'd5);
    send_req(FUNC_RECAL, '0, 32'd10);
    send_req(FUNC_SAMPLE, 10'd0, 32'd20);
    send_req(FUNC_SAMPLE, 10'd1023, 32'd400);
    send_req(FUNC_SAMPLE, 10'd1023, 32'd420);
    send_req(FUNC_SAMPLE, 10'd2, 32'd430);
    send_req(FUNC_SAMPLE, 10'd0, 32'd440);
    send_req(FUNC_CONSUME, '0, 32'd450);
    send_req(FUNC_CONSUME, '0, 32'd460);
    send_req(FUNC_SAMPLE, 10'd1023, 32'd500);
    send_req(FUNC_SAMPLE, 10'd0, 32'd510);
    send_req(FUNC_SAMPLE, 10'd1023, 32'd2000);
    send_req(FUNC_SAMPLE, 10'd0, 32'hFFFF_FE00);
    send_req(FUNC_SAMPLE, 10'd1023, 32'hFFFF_FF00);
    send_req(FUNC_SAMPLE, 10'd0, 32'hFFFF_FFA0);
    send_req(FUNC_SAMPLE, 10'd1023, 32'h0000_01F4);
    wait_idle();

    // zero interval crossing, accepted with min_rate 0; then an out-of-range rate
    write_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1023);
    send_req(FUNC_RECAL, '0, 32'h8000_0000);
    send_req(FUNC_SAMPLE, 10'd0, 32'h8000_0000);
    send_req(FUNC_SAMPLE, 10'd1023, 32'h8000_0000);
    send_req(FUNC_CONSUME, '0, 32'h8000_0000);
    send_req(FUNC_SAMPLE, 10'd1023, 32'h8000_0001);
    send_req(FUNC_SAMPLE, 10'd0, 32'h8000_0002);
    send_req(FUNC_SAMPLE, 10'd1023, 32'h8000_0003);
    wait_idle();

    write_regs(16'd655, 16'd3277, 16'd128, 16'd300, 16'd40, 16'd200);
    run_pulses(200);
    wait_idle();
    write_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_pulses(200);
    wait_idle();

    send_idle_pct = 87;
    recv_idle_pct = 21;
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_pulses(200);
    wait_idle();
    write_regs(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
               CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()));
    run_pulses(200);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_regs(CFG_W'($urandom_range(4000, 200)), CFG_W'($urandom_range(8000, 1000)),
               CFG_W'($urandom_range(512, 64)), CFG_W'($urandom_range(400, 0)),
               CFG_W'($urandom_range(60, 0)), CFG_W'($urandom_range(1023, 150)));
    holds_asked++;
    run_pulses(100);
    wait_idle();
    run_pulses(100);
    wait_idle();
    write_regs(16'd655, 16'd3277, 16'd128, 16'd0, 16'd0, 16'd200);
    run_pulses(200);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
